>>> src/prc_pkg.sv
`timescale 1ns / 1ps
package prc_pkg;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MAGIC  = 3'd1;
  localparam logic [2:0] ST_LENGTH = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;

  localparam logic [1:0] OP_CRC   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  localparam logic       CFG_MAX_PAYLOAD = 1'b0;
  localparam logic       CFG_CRC_POLY    = 1'b1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd65524;
  localparam logic [31:0] CRC_POLY_RESET    = 32'h04c10db7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        first;
    logic        zero;
    logic [2:0]  status;
    logic [15:0] length;
    logic [31:0] stored;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] length;
    logic [31:0] crc;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = 8'h50;
      2'd1: m = 8'h41;
      2'd2: m = 8'h52;
      2'd3: m = 8'h4d;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> src/parm_record_checker_top.sv
`timescale 1ns / 1ps
// verdict path: the op that settles a verdict passes through the op queue; the verdict is
// written to the result queue, which drives the out_ ports; it waits while that queue is full
// throughput: one byte per cycle; in_full only rises when the op queue backs up
// behind a full result queue
// reset: synchronous active-low rst_n empties both queues, idles the parser
// and loads max_payload 65524 and polynomial 0x04c10db7
module parm_record_checker_top
  import prc_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = 65536,
  parameter int OPQ_AW           = 2,
  parameter int RESQ_AW          = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_payload_length,
  output logic [31:0] out_computed_crc,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [15:0] max_payload_r;
  logic [31:0] crc_poly_r;
  logic        accept;
  logic        op_push, op_pop, opq_empty, res_push, res_full;
  op_t         op_in, op_out;
  result_t     res_in, res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
      crc_poly_r    <= CRC_POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata[15:0];
        CFG_CRC_POLY:    crc_poly_r    <= cfg_wdata;
        default:         crc_poly_r    <= crc_poly_r;
      endcase
    end
  end

  assign accept = in_push && !in_full;

  prc_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .record_start(in_record_start),
    .max_payload (max_payload_r),
    .op_push     (op_push),
    .op_data     (op_in)
  );

  prc_fifo #(
    .WIDTH($bits(op_t)),
    .AW   (OPQ_AW)
  ) u_opq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (op_push),
    .wdata(op_in),
    .pop  (op_pop),
    .rdata(op_out),
    .full (in_full),
    .empty(opq_empty)
  );

  prc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_valid(!opq_empty),
    .op_data (op_out),
    .op_pop  (op_pop),
    .crc_poly(crc_poly_r),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in)
  );

  prc_fifo #(
    .WIDTH($bits(result_t)),
    .AW   (RESQ_AW)
  ) u_resq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .pop  (out_pop),
    .rdata(res_out),
    .full (res_full),
    .empty(out_empty)
  );

  assign out_status         = res_out.status;
  assign out_payload_length = res_out.length;
  assign out_computed_crc   = res_out.crc;

endmodule

>>> src/prc_fifo.sv
`timescale 1ns / 1ps
module prc_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_comb begin
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
      wptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule

>>> src/prc_front.sv
`timescale 1ns / 1ps
module prc_front
  import prc_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        record_start,
  input  logic [15:0] max_payload,
  output logic        op_push,
  output op_t         op_data
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [31:0] LIMIT_CAP = 32'(MAX_RECORD_BYTES - 12);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] limit;

  assign limit = ({16'd0, max_payload} < LIMIT_CAP) ? {16'd0, max_payload} : LIMIT_CAP;

  always_comb begin
    logic [2:0]  ph;
    logic [15:0] pos;
    logic [31:0] len;
    logic [31:0] stored;
    logic        zero;
    logic [16:0] pos_inc;
    ph      = record_start ? PH_MAGIC : phase_r;
    pos     = record_start ? 16'd0 : pos_r;
    len     = record_start ? 32'd0 : len_r;
    stored  = record_start ? 32'd0 : stored_r;
    zero    = record_start ? 1'b0 : zero_r;
    pos_inc = {1'b0, pos} + 17'd1;

    phase_nxt  = ph;
    pos_nxt    = pos;
    len_nxt    = len;
    stored_nxt = stored;
    zero_nxt   = zero;
    op_push    = 1'b0;
    op_data    = '0;

    unique case (ph)
      PH_MAGIC: begin
        if (data_byte != magic_byte(pos[1:0])) begin
          op_push        = 1'b1;
          op_data.kind   = OP_FAIL;
          op_data.status = ST_MAGIC;
          phase_nxt      = PH_DONE;
        end else if (pos[1:0] == 2'd3) begin
          phase_nxt = PH_LEN;
          pos_nxt   = 16'd0;
        end else begin
          pos_nxt = pos_inc[15:0];
        end
      end
      PH_LEN: begin
        len_nxt = len | ({24'd0, data_byte} << {pos[1:0], 3'b000});
        if (pos[1:0] != 2'd3) begin
          pos_nxt = pos_inc[15:0];
        end else if (len_nxt == 32'd0 || len_nxt > limit) begin
          op_push        = 1'b1;
          op_data.kind   = OP_FAIL;
          op_data.status = ST_LENGTH;
          phase_nxt      = PH_DONE;
        end else begin
          phase_nxt = PH_PAYLOAD;
          pos_nxt   = 16'd0;
        end
      end
      PH_PAYLOAD: begin
        op_push       = 1'b1;
        op_data.kind  = OP_CRC;
        op_data.data  = data_byte;
        op_data.first = (pos == 16'd0);
        if (data_byte == 8'd0 && pos_inc < len[16:0]) begin
          zero_nxt = 1'b1;
        end
        if (pos_inc == len[16:0]) begin
          phase_nxt = PH_CRC;
          pos_nxt   = 16'd0;
        end else begin
          pos_nxt = pos_inc[15:0];
        end
      end
      PH_CRC: begin
        stored_nxt = stored | ({24'd0, data_byte} << {pos[1:0], 3'b000});
        if (pos[1:0] != 2'd3) begin
          pos_nxt = pos_inc[15:0];
        end else begin
          op_push        = 1'b1;
          op_data.kind   = OP_CHECK;
          op_data.zero   = zero;
          op_data.length = len[15:0];
          op_data.stored = stored_nxt;
          phase_nxt      = PH_DONE;
        end
      end
      default: begin
        phase_nxt = ph;
      end
    endcase

    if (!accept) begin
      op_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      len_r    <= '0;
      stored_r <= '0;
      zero_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      stored_r <= stored_nxt;
      zero_r   <= zero_nxt;
    end
  end

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (len_r != 32'd0 && {16'd0, pos_r} < len_r))
    else $error("payload position out of range");

  a_short_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MAGIC || phase_r == PH_LEN || phase_r == PH_CRC) |-> (pos_r < 16'd4))
    else $error("header position out of range");

  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && accept && !record_start) |-> !op_push)
    else $error("op issued after verdict");

endmodule

>>> src/prc_back.sv
`timescale 1ns / 1ps
module prc_back
  import prc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  op_t         op_data,
  output logic        op_pop,
  input  logic [31:0] crc_poly,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res_data
);

  logic [31:0] crc_r, crc_nxt;

  function automatic logic [31:0] crc_step(input logic [31:0] crc_in, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ poly) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  assign op_pop = op_valid && (op_data.kind == OP_CRC || !res_full);

  always_comb begin
    crc_nxt  = crc_r;
    res_push = 1'b0;
    res_data = '0;
    if (op_pop) begin
      unique case (op_data.kind)
        OP_CRC: begin
          crc_nxt = crc_step(op_data.first ? 32'd0 : crc_r, op_data.data, crc_poly);
        end
        OP_CHECK: begin
          res_push        = 1'b1;
          res_data.length = op_data.length;
          res_data.crc    = crc_r;
          if (op_data.stored != crc_r) begin
            res_data.status = ST_CRC;
          end else if (op_data.zero) begin
            res_data.status = ST_ZERO;
          end else begin
            res_data.status = ST_OK;
          end
        end
        OP_FAIL: begin
          res_push        = 1'b1;
          res_data.status = op_data.status;
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res_data.status == ST_MAGIC || res_data.status == ST_LENGTH))
      |-> (res_data.length == 16'd0 && res_data.crc == 32'd0))
    else $error("failed verdict carries length or crc");

endmodule
